// File: rtl/core/swdhte_pkg.sv
// Types and constants shared by the SWD host transfer engine.
`timescale 1ns / 1ps
`default_nettype none

package swdhte_pkg;

	// Counter and field widths
	localparam int CNT_W      = 6;
	localparam int DATA_W     = 32;
	localparam int IDLE_W     = 8;
	localparam int SEQ_W      = 8;

	// Bit counts of the frame phases
	localparam logic [CNT_W-1:0] REQ_BITS   = 6'd8;
	localparam logic [CNT_W-1:0] ACK_BITS   = 6'd3;
	localparam logic [CNT_W-1:0] DATA_BITS  = 6'd32;
	localparam logic [CNT_W-1:0] FRAME_BITS = 6'd33;
	localparam logic [3:0]       SEQ_MAX    = 4'd8;

	// Request type codes
	localparam logic [1:0] REQ_TICK = 2'd0;
	localparam logic [1:0] REQ_XFER = 2'd1;
	localparam logic [1:0] REQ_SEQ  = 2'd2;
	localparam logic [1:0] REQ_NONE = 2'd3;

	// Acknowledge codes
	localparam logic [2:0] ACK_OK    = 3'd1;
	localparam logic [2:0] ACK_WAIT  = 3'd2;
	localparam logic [2:0] ACK_FAULT = 3'd4;

	// Transfer status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_WAIT    = 3'd1;
	localparam logic [2:0] ST_FAULT   = 3'd2;
	localparam logic [2:0] ST_PARITY  = 3'd3;
	localparam logic [2:0] ST_BAD_ACK = 3'd4;

	typedef struct packed {
		logic [1:0]  req_type;
		logic        ap_not_dp;
		logic        read_not_write;
		logic [1:0]  reg_addr;
		logic [31:0] write_data;
		logic [7:0]  seq_bits;
		logic [3:0]  seq_count;
		logic        swdio_in;
	} item_t;

	typedef struct packed {
		logic        swdio_out;
		logic        swdio_drive;
		logic        clock_active;
		logic        done_res;
		logic [2:0]  ack;
		logic [2:0]  status;
		logic [31:0] read_data;
	} res_t;

	typedef enum logic [13:0] {
		PH_IDLE   = 14'b00000000000001,
		PH_REQ    = 14'b00000000000010,
		PH_TRN1   = 14'b00000000000100,
		PH_ACK    = 14'b00000000001000,
		PH_RDATA  = 14'b00000000010000,
		PH_RTRN   = 14'b00000000100000,
		PH_WTRN   = 14'b00000001000000,
		PH_WDATA  = 14'b00000010000000,
		PH_IDLEB  = 14'b00000100000000,
		PH_DUMRD  = 14'b00001000000000,
		PH_ERRTRN = 14'b00010000000000,
		PH_DUMWR  = 14'b00100000000000,
		PH_BADTRN = 14'b01000000000000,
		PH_SEQ    = 14'b10000000000000
	} phase_t;

endpackage

`default_nettype wire

// File: rtl/core/swd_host_transfer_engine_core.sv
// SWD host transfer engine: request, ACK, data, idle and line sequence bit sequencing per tick.
//
//  channel | signals                        | direction | moves
//  --------+--------------------------------+-----------+-----------------------------
//  item    | item_valid, item_ready, item   | in        | tick, transfer or sequence
//  res     | res_valid, res_ready, res      | out       | one bit period per busy tick
//  cfg     | cfg_valid, cfg_ready, cfg_data | in        | idle_cycles register write
//
// One item per cycle while no result stalls. An accepted item lands in the input
// register and is decoded against the phase state when it leaves that register,
// and the same edge loads its result, if it issues one, into the result register. The result
// register and the input register stall together only when a result is waiting
// and res_ready is low.
// Reset leaves the engine idle with no clearing pass; cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module swd_host_transfer_engine_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           item_valid,
	output logic                          item_ready,
	input  swdhte_pkg::item_t             item,
	output logic                          res_valid,
	input  wire                           res_ready,
	output swdhte_pkg::res_t              res,
	input  wire                           cfg_valid,
	output logic                          cfg_ready,
	input  wire  [swdhte_pkg::IDLE_W-1:0] cfg_data
);

	localparam int CW = swdhte_pkg::CNT_W;
	localparam int IW = swdhte_pkg::IDLE_W;
	localparam int DW = swdhte_pkg::DATA_W;
	localparam int SW = swdhte_pkg::SEQ_W;

	// Input stage
	swdhte_pkg::item_t item_s1;
	logic              item_vld_s1;
	logic              go;

	// Engine state
	swdhte_pkg::phase_t phase_q, phase_n;
	logic [CW-1:0]      bit_cnt_q, bit_cnt_n;
	logic [3:0]         req_latch_q, req_latch_n;
	logic [DW-1:0]      wr_shift_q, wr_shift_n;
	logic [DW-1:0]      rd_shift_q, rd_shift_n;
	logic               par_q, par_n;
	logic [2:0]         ack_q, ack_n;
	logic [IW-1:0]      idle_left_q, idle_left_n;
	logic [SW-1:0]      seq_shift_q, seq_shift_n;
	logic [IW-1:0]      idle_cycles_q;

	// Result stage
	swdhte_pkg::res_t res_q, res_n;
	logic             res_vld_q;
	logic             emit;

	// Decode helpers
	logic          rnw;
	logic          din;
	logic [CW-1:0] cnt_inc;
	logic [7:0]    req_word;
	logic          fin;
	logic [2:0]    fin_st;
	logic          beg_idle;

	assign go         = item_vld_s1 && (!res_vld_q || res_ready);
	assign item_ready = !item_vld_s1 || go;
	assign cfg_ready  = 1'b1;
	assign res_valid  = res_vld_q;
	assign res        = res_q;

	assign rnw      = req_latch_q[1];
	assign din      = item_s1.swdio_in;
	assign cnt_inc  = bit_cnt_q + 6'd1;
	// start, APnDP, RnW, A2, A3, parity, stop, park (LSB first)
	assign req_word = {1'b1, 1'b0, ^req_latch_q, req_latch_q, 1'b1};

	// Hold the configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			idle_cycles_q <= cfg_data;
		end
	end

	// Advance the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_vld_s1 <= 1'b0;
		end else if (item_ready) begin
			item_vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	// Decode one request against the current phase
	always_comb begin
		phase_n     = phase_q;
		bit_cnt_n   = bit_cnt_q;
		req_latch_n = req_latch_q;
		wr_shift_n  = wr_shift_q;
		rd_shift_n  = rd_shift_q;
		par_n       = par_q;
		ack_n       = ack_q;
		idle_left_n = idle_left_q;
		seq_shift_n = seq_shift_q;
		res_n       = '0;
		res_n.clock_active = 1'b1;
		emit        = 1'b0;
		fin         = 1'b0;
		fin_st      = swdhte_pkg::ST_OK;
		beg_idle    = 1'b0;

		if (go) begin
			unique case (item_s1.req_type)
				swdhte_pkg::REQ_XFER: begin
					if (phase_q == swdhte_pkg::PH_IDLE) begin
						req_latch_n = {item_s1.reg_addr, item_s1.read_not_write,
							item_s1.ap_not_dp};
						wr_shift_n  = item_s1.write_data;
						rd_shift_n  = '0;
						par_n       = 1'b0;
						ack_n       = '0;
						bit_cnt_n   = '0;
						phase_n     = swdhte_pkg::PH_REQ;
					end
				end
				swdhte_pkg::REQ_SEQ: begin
					if (phase_q == swdhte_pkg::PH_IDLE && item_s1.seq_count != 4'd0) begin
						seq_shift_n = item_s1.seq_bits;
						bit_cnt_n   = (item_s1.seq_count > swdhte_pkg::SEQ_MAX)
							? CW'(swdhte_pkg::SEQ_MAX) : CW'(item_s1.seq_count);
						phase_n     = swdhte_pkg::PH_SEQ;
					end
				end
				swdhte_pkg::REQ_NONE: begin
				end
				swdhte_pkg::REQ_TICK: begin
					emit = (phase_q != swdhte_pkg::PH_IDLE);
					unique case (phase_q)
						swdhte_pkg::PH_IDLE: begin
						end
						swdhte_pkg::PH_REQ: begin
							res_n.swdio_out   = req_word[bit_cnt_q[2:0]];
							res_n.swdio_drive = 1'b1;
							bit_cnt_n = cnt_inc;
							if (cnt_inc >= swdhte_pkg::REQ_BITS) begin
								bit_cnt_n = '0;
								phase_n   = swdhte_pkg::PH_TRN1;
							end
						end
						swdhte_pkg::PH_TRN1: begin
							bit_cnt_n = '0;
							ack_n     = '0;
							phase_n   = swdhte_pkg::PH_ACK;
						end
						swdhte_pkg::PH_ACK: begin
							ack_n     = ack_q | ({2'b00, din} << bit_cnt_q[1:0]);
							bit_cnt_n = cnt_inc;
							if (cnt_inc >= swdhte_pkg::ACK_BITS) begin
								bit_cnt_n = '0;
								par_n     = 1'b0;
								if (ack_n == swdhte_pkg::ACK_OK) begin
									rd_shift_n = '0;
									phase_n = rnw ? swdhte_pkg::PH_RDATA : swdhte_pkg::PH_WTRN;
								end else if (ack_n == swdhte_pkg::ACK_WAIT ||
									ack_n == swdhte_pkg::ACK_FAULT) begin
									phase_n = rnw ? swdhte_pkg::PH_DUMRD : swdhte_pkg::PH_ERRTRN;
								end else begin
									phase_n = swdhte_pkg::PH_BADTRN;
								end
							end
						end
						swdhte_pkg::PH_RDATA: begin
							if (bit_cnt_q < swdhte_pkg::DATA_BITS) begin
								rd_shift_n = rd_shift_q | (DW'(din) << bit_cnt_q[4:0]);
							end
							par_n     = par_q ^ din;
							bit_cnt_n = cnt_inc;
							if (cnt_inc >= swdhte_pkg::FRAME_BITS) begin
								bit_cnt_n = '0;
								phase_n   = swdhte_pkg::PH_RTRN;
							end
						end
						swdhte_pkg::PH_RTRN: begin
							if (par_q) begin
								fin    = 1'b1;
								fin_st = swdhte_pkg::ST_PARITY;
							end else begin
								beg_idle = 1'b1;
							end
						end
						swdhte_pkg::PH_WTRN: begin
							bit_cnt_n = '0;
							par_n     = 1'b0;
							phase_n   = swdhte_pkg::PH_WDATA;
						end
						swdhte_pkg::PH_WDATA: begin
							res_n.swdio_drive = 1'b1;
							if (bit_cnt_q < swdhte_pkg::DATA_BITS) begin
								res_n.swdio_out = wr_shift_q[bit_cnt_q[4:0]];
								par_n = par_q ^ wr_shift_q[bit_cnt_q[4:0]];
							end else begin
								res_n.swdio_out = par_q;
							end
							bit_cnt_n = cnt_inc;
							if (cnt_inc >= swdhte_pkg::FRAME_BITS) begin
								beg_idle = 1'b1;
							end
						end
						swdhte_pkg::PH_IDLEB: begin
							res_n.swdio_drive = 1'b1;
							if (idle_left_q != '0) begin
								idle_left_n = idle_left_q - 8'd1;
							end
							if (idle_left_n == '0) begin
								fin = 1'b1;
							end
						end
						swdhte_pkg::PH_DUMRD: begin
							bit_cnt_n = cnt_inc;
							if (cnt_inc >= swdhte_pkg::FRAME_BITS) begin
								bit_cnt_n = '0;
								phase_n   = swdhte_pkg::PH_ERRTRN;
							end
						end
						swdhte_pkg::PH_ERRTRN: begin
							if (rnw) begin
								fin    = 1'b1;
								fin_st = (ack_q == swdhte_pkg::ACK_WAIT)
									? swdhte_pkg::ST_WAIT : swdhte_pkg::ST_FAULT;
							end else begin
								bit_cnt_n = '0;
								phase_n   = swdhte_pkg::PH_DUMWR;
							end
						end
						swdhte_pkg::PH_DUMWR: begin
							res_n.swdio_drive = 1'b1;
							bit_cnt_n = cnt_inc;
							if (cnt_inc >= swdhte_pkg::FRAME_BITS) begin
								fin    = 1'b1;
								fin_st = (ack_q == swdhte_pkg::ACK_WAIT)
									? swdhte_pkg::ST_WAIT : swdhte_pkg::ST_FAULT;
							end
						end
						swdhte_pkg::PH_BADTRN: begin
							fin    = 1'b1;
							fin_st = swdhte_pkg::ST_BAD_ACK;
						end
						swdhte_pkg::PH_SEQ: begin
							res_n.swdio_out   = seq_shift_q[0];
							res_n.swdio_drive = 1'b1;
							seq_shift_n = seq_shift_q >> 1;
							if (bit_cnt_q != '0) begin
								bit_cnt_n = bit_cnt_q - 6'd1;
							end
							if (bit_cnt_n == '0) begin
								res_n.done_res = 1'b1;
								phase_n = swdhte_pkg::PH_IDLE;
							end
						end
						default: begin
							emit      = 1'b0;
							phase_n   = swdhte_pkg::PH_IDLE;
							bit_cnt_n = '0;
						end
					endcase
				end
			endcase

			// Start the idle bits, or end at once when none are configured
			if (beg_idle) begin
				idle_left_n = idle_cycles_q;
				bit_cnt_n   = '0;
				if (idle_cycles_q == '0) begin
					fin = 1'b1;
				end else begin
					phase_n = swdhte_pkg::PH_IDLEB;
				end
			end

			// Close the transfer and report
			if (fin) begin
				res_n.done_res  = 1'b1;
				res_n.ack       = ack_q;
				res_n.status    = fin_st;
				res_n.read_data = (fin_st == swdhte_pkg::ST_OK && rnw) ? rd_shift_q : '0;
				phase_n   = swdhte_pkg::PH_IDLE;
				bit_cnt_n = '0;
			end
		end
	end

	// Hold the engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= swdhte_pkg::PH_IDLE;
			bit_cnt_q   <= '0;
			req_latch_q <= '0;
			rd_shift_q  <= '0;
			par_q       <= 1'b0;
			ack_q       <= '0;
			idle_left_q <= '0;
			seq_shift_q <= '0;
		end else begin
			phase_q     <= phase_n;
			bit_cnt_q   <= bit_cnt_n;
			req_latch_q <= req_latch_n;
			rd_shift_q  <= rd_shift_n;
			par_q       <= par_n;
			ack_q       <= ack_n;
			idle_left_q <= idle_left_n;
			seq_shift_q <= seq_shift_n;
		end
	end

	always_ff @(posedge clk) begin
		wr_shift_q <= wr_shift_n;
	end

	// Load the result register, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (go) begin
			res_vld_q <= emit;
		end else if (res_ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			res_q <= res_n;
		end
	end

endmodule

`default_nettype wire

// File: dv/tb_swd_host_transfer_engine_core.sv
// Self-checking testbench for the SWD host transfer engine core.
`timescale 1ns / 1ps

module tb_swd_host_transfer_engine_core;
	import swdhte_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_HOLD      = 400;
	localparam int SETTLE_CYCLES  = 6;
	localparam int TAIL_CYCLES    = 8;

	// Line levels driven back during the ACK phase that decode to no valid ACK
	localparam logic [2:0] ACK_LINE_LOW  = 3'b000;
	localparam logic [2:0] ACK_LINE_HIGH = 3'b111;

	// How the target fills read data bits
	localparam logic [1:0] FILL_RAND = 2'd0;
	localparam logic [1:0] FILL_ZERO = 2'd1;
	localparam logic [1:0] FILL_ONES = 2'd2;

	// Tracks the engine's bit sequencing and holds the bit periods still due
	class swd_bit_scoreboard;
		logic [IDLE_W-1:0] idle_cfg;
		phase_t            ph;
		logic [CNT_W-1:0]  bit_cnt;
		logic [3:0]        req_lat;
		logic [31:0]       wr_word;
		logic [31:0]       rd_word;
		logic              par;
		logic [2:0]        ack_lat;
		logic [IDLE_W-1:0] idle_left;
		logic [SEQ_W-1:0]  seq_sr;
		res_t              cur;
		res_t              bits_due[$];
		int unsigned       errors;

		function new();
			idle_cfg  = '0;
			ph        = PH_IDLE;
			bit_cnt   = '0;
			req_lat   = '0;
			wr_word   = '0;
			rd_word   = '0;
			par       = 1'b0;
			ack_lat   = '0;
			idle_left = '0;
			seq_sr    = '0;
			errors    = 0;
		endfunction

		// Mark the last bit of a transfer and return to idle
		function void close_xfer(logic [2:0] st);
			cur.done_res  = 1'b1;
			cur.ack       = ack_lat;
			cur.status    = st;
			cur.read_data = (st == ST_OK && req_lat[1]) ? rd_word : '0;
			ph            = PH_IDLE;
			bit_cnt       = '0;
		endfunction

		// Enter the idle bit phase, or finish at once with no idle bits
		function void open_idle();
			idle_left = idle_cfg;
			bit_cnt   = '0;
			if (idle_left == 0)
				close_xfer(ST_OK);
			else
				ph = PH_IDLEB;
		endfunction

		// Advance on one accepted request; queue the bit period it issues
		function void take_request(item_t it);
			logic [7:0]  rq;
			logic        rnw;
			logic        b;
			int unsigned n;
			rnw = req_lat[1];
			if (it.req_type == REQ_XFER || it.req_type == REQ_SEQ) begin
				if (ph != PH_IDLE)
					return;
				if (it.req_type == REQ_XFER) begin
					req_lat = {it.reg_addr, it.read_not_write, it.ap_not_dp};
					wr_word = it.write_data;
					rd_word = '0;
					par     = 1'b0;
					ack_lat = '0;
					bit_cnt = '0;
					ph      = PH_REQ;
				end else begin
					n = {28'd0, it.seq_count};
					if (n == 0)
						return;
					if (n > SEQ_MAX)
						n = {28'd0, SEQ_MAX};
					seq_sr  = it.seq_bits;
					bit_cnt = CNT_W'(n);
					ph      = PH_SEQ;
				end
				return;
			end
			if (it.req_type != REQ_TICK || ph == PH_IDLE)
				return;

			cur = '0;
			cur.clock_active = 1'b1;
			case (ph)
				PH_REQ: begin
					rq = {1'b1, 1'b0, ^req_lat, req_lat, 1'b1};
					cur.swdio_out   = rq[bit_cnt[2:0]];
					cur.swdio_drive = 1'b1;
					bit_cnt++;
					if (bit_cnt >= REQ_BITS) begin
						bit_cnt = '0;
						ph      = PH_TRN1;
					end
				end
				PH_TRN1: begin
					bit_cnt = '0;
					ack_lat = '0;
					ph      = PH_ACK;
				end
				PH_ACK: begin
					ack_lat[bit_cnt[1:0]] = ack_lat[bit_cnt[1:0]] | it.swdio_in;
					bit_cnt++;
					if (bit_cnt >= ACK_BITS) begin
						bit_cnt = '0;
						par     = 1'b0;
						if (ack_lat == ACK_OK) begin
							rd_word = '0;
							ph      = rnw ? PH_RDATA : PH_WTRN;
						end else if (ack_lat == ACK_WAIT || ack_lat == ACK_FAULT) begin
							ph = rnw ? PH_DUMRD : PH_ERRTRN;
						end else begin
							ph = PH_BADTRN;
						end
					end
				end
				PH_RDATA: begin
					if (bit_cnt < DATA_BITS)
						rd_word[bit_cnt[4:0]] = it.swdio_in;
					par = par ^ it.swdio_in;
					bit_cnt++;
					if (bit_cnt >= FRAME_BITS) begin
						bit_cnt = '0;
						ph      = PH_RTRN;
					end
				end
				PH_RTRN: begin
					if (par)
						close_xfer(ST_PARITY);
					else
						open_idle();
				end
				PH_WTRN: begin
					bit_cnt = '0;
					par     = 1'b0;
					ph      = PH_WDATA;
				end
				PH_WDATA: begin
					cur.swdio_drive = 1'b1;
					if (bit_cnt < DATA_BITS) begin
						b   = wr_word[bit_cnt[4:0]];
						par = par ^ b;
						cur.swdio_out = b;
					end else begin
						cur.swdio_out = par;
					end
					bit_cnt++;
					if (bit_cnt >= FRAME_BITS)
						open_idle();
				end
				PH_IDLEB: begin
					cur.swdio_drive = 1'b1;
					if (idle_left > 0)
						idle_left--;
					if (idle_left == 0)
						close_xfer(ST_OK);
				end
				PH_DUMRD: begin
					bit_cnt++;
					if (bit_cnt >= FRAME_BITS) begin
						bit_cnt = '0;
						ph      = PH_ERRTRN;
					end
				end
				PH_ERRTRN: begin
					if (rnw) begin
						close_xfer(ack_lat == ACK_WAIT ? ST_WAIT : ST_FAULT);
					end else begin
						bit_cnt = '0;
						ph      = PH_DUMWR;
					end
				end
				PH_DUMWR: begin
					cur.swdio_drive = 1'b1;
					bit_cnt++;
					if (bit_cnt >= FRAME_BITS)
						close_xfer(ack_lat == ACK_WAIT ? ST_WAIT : ST_FAULT);
				end
				PH_BADTRN: begin
					close_xfer(ST_BAD_ACK);
				end
				PH_SEQ: begin
					cur.swdio_out   = seq_sr[0];
					cur.swdio_drive = 1'b1;
					seq_sr = seq_sr >> 1;
					if (bit_cnt > 0)
						bit_cnt--;
					if (bit_cnt == 0) begin
						cur.done_res = 1'b1;
						ph           = PH_IDLE;
					end
				end
				default: begin
					ph      = PH_IDLE;
					bit_cnt = '0;
					return;
				end
			endcase
			bits_due.push_back(cur);
		endfunction

		function void cmp(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s mismatch: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		// Compare one delivered bit period against the oldest one due
		function void check_bit(res_t got);
			res_t want;
			if (bits_due.size() == 0) begin
				$error("bit period %h delivered with none due", got);
				errors++;
				return;
			end
			want = bits_due.pop_front();
			cmp("swdio_out", 32'(want.swdio_out), 32'(got.swdio_out));
			cmp("swdio_drive", 32'(want.swdio_drive), 32'(got.swdio_drive));
			cmp("clock_active", 32'(want.clock_active), 32'(got.clock_active));
			cmp("done_res", 32'(want.done_res), 32'(got.done_res));
			cmp("ack", 32'(want.ack), 32'(got.ack));
			cmp("status", 32'(want.status), 32'(got.status));
			cmp("read_data", want.read_data, got.read_data);
		endfunction
	endclass

	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              item_valid = 1'b0;
	logic              item_ready;
	item_t             item       = '0;
	logic              res_valid;
	logic              res_ready  = 1'b0;
	res_t              res;
	logic              cfg_valid  = 1'b0;
	logic              cfg_ready;
	logic [IDLE_W-1:0] cfg_data   = '0;

	swd_bit_scoreboard sb = new();

	// Target behavior for the transfer in flight
	logic [2:0]  plan_ack     = ACK_OK;
	logic        plan_bad_par = 1'b0;
	logic [1:0]  plan_fill    = FILL_RAND;
	int unsigned tx_gap_pct   = 0;
	bit          hold_req     = 1'b0;
	int unsigned quiet_cycles = 0;

	swd_host_transfer_engine_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item      (item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Mostly short gaps, now and then a long one
	function automatic int unsigned gap_len();
		if ($urandom_range(9) == 0)
			return $urandom_range(40, 8);
		return $urandom_range(3, 1);
	endfunction

	function automatic item_t rand_item();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[$bits(item_t)-1:0];
	endfunction

	function automatic item_t cmd_of(logic [1:0] rt);
		item_t it;
		it = rand_item();
		it.req_type = rt;
		return it;
	endfunction

	function automatic item_t xfer(logic ap, logic rnw, logic [1:0] addr, logic [31:0] wd);
		item_t it;
		it = cmd_of(REQ_XFER);
		it.ap_not_dp      = ap;
		it.read_not_write = rnw;
		it.reg_addr       = addr;
		it.write_data     = wd;
		return it;
	endfunction

	function automatic item_t seqc(logic [7:0] bits, logic [3:0] cnt);
		item_t it;
		it = cmd_of(REQ_SEQ);
		it.seq_bits  = bits;
		it.seq_count = cnt;
		return it;
	endfunction

	// Build a tick whose line level plays the target side of the plan
	function automatic item_t make_tick();
		item_t it;
		it = cmd_of(REQ_TICK);
		if (sb.ph == PH_ACK) begin
			it.swdio_in = plan_ack[sb.bit_cnt[1:0]];
		end else if (sb.ph == PH_RDATA) begin
			if (sb.bit_cnt == DATA_BITS)
				it.swdio_in = sb.par ^ plan_bad_par;
			else if (plan_fill == FILL_ZERO)
				it.swdio_in = 1'b0;
			else if (plan_fill == FILL_ONES)
				it.swdio_in = 1'b1;
		end
		return it;
	endfunction

	function automatic void pick_plan();
		int unsigned x;
		x = $urandom_range(99);
		if (x < 70)
			plan_ack = ACK_OK;
		else if (x < 80)
			plan_ack = ACK_WAIT;
		else if (x < 90)
			plan_ack = ACK_FAULT;
		else
			plan_ack = 3'($urandom_range(7));
		plan_bad_par = ($urandom_range(99) < 15);
		plan_fill = ($urandom_range(9) == 0) ? 2'($urandom_range(2, 1)) : FILL_RAND;
	endfunction

	// Offer one request and hold it until accepted
	task automatic send(input item_t it);
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		sb.take_request(it);
	endtask

	task automatic pace();
		if ($urandom_range(99) < tx_gap_pct) begin
			item_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
	endtask

	// Tick until the engine is back to idle
	task automatic drain();
		while (sb.ph != PH_IDLE) begin
			pace();
			send(make_tick());
		end
	endtask

	task automatic run_cmd(input item_t cmd, input logic [2:0] ack, input logic bad_par,
			input logic [1:0] fill, input bit poke);
		plan_ack     = ack;
		plan_bad_par = bad_par;
		plan_fill    = fill;
		pace();
		send(cmd);
		// Starts while busy must be dropped
		if (poke) begin
			send(xfer(1'b1, 1'b1, 2'd2, $urandom));
			send(seqc(8'h5a, 4'd8));
		end
		drain();
	endtask

	// Wait until every due bit period has been seen and the pipeline is empty
	task automatic settle();
		item_valid <= 1'b0;
		while (sb.bits_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_idle(input logic [IDLE_W-1:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.idle_cfg = v;
		cfg_valid <= 1'b0;
	endtask

	// Mostly well-formed transfers and sequences, with some noise mixed in
	task automatic random_phase(input int unsigned n);
		item_t       it;
		int unsigned r;
		for (int k = 0; k < n; k++) begin
			pace();
			if (sb.ph == PH_IDLE) begin
				r = $urandom_range(99);
				if (r < 65) begin
					it = cmd_of(REQ_XFER);
					pick_plan();
				end else if (r < 85) begin
					it = cmd_of(REQ_SEQ);
					if ($urandom_range(9) != 0)
						it.seq_count = 4'($urandom_range(8, 1));
				end else if (r < 93) begin
					it = cmd_of(REQ_TICK);
				end else begin
					it = cmd_of(REQ_NONE);
				end
			end else if ($urandom_range(99) < 3) begin
				it = rand_item();
				if (it.req_type == REQ_TICK)
					it.req_type = REQ_XFER;
			end else begin
				it = make_tick();
			end
			send(it);
		end
		drain();
	endtask

	// Check each delivered bit period
	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check_bit(res);
	end

	// Stall the result side at random, with one long hold-off on request
	initial begin : res_side
		int unsigned stall_pct;
		int unsigned epoch;
		stall_pct = 0;
		epoch     = 0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (epoch == 0) begin
				epoch = 128;
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 10;
					default: stall_pct = 35;
				endcase
			end
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if ($urandom_range(99) < stall_pct) begin
				res_ready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end else begin
				res_ready <= 1'b1;
				@(posedge clk);
			end
			epoch--;
		end
	end

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_swd_host_transfer_engine_core: FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		logic [IDLE_W-1:0] v;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_gap_pct = 20;

		// Idle-time requests that issue nothing
		run_cmd(cmd_of(REQ_TICK), ACK_OK, 1'b0, FILL_RAND, 1'b0);
		run_cmd(cmd_of(REQ_NONE), ACK_OK, 1'b0, FILL_RAND, 1'b0);
		run_cmd(seqc(8'hff, 4'd0), ACK_OK, 1'b0, FILL_RAND, 1'b0);

		// Line sequences: full, single bit, oversized count
		run_cmd(seqc(8'hff, 4'd8), ACK_OK, 1'b0, FILL_RAND, 1'b0);
		run_cmd(seqc(8'ha5, 4'd1), ACK_OK, 1'b0, FILL_RAND, 1'b0);
		run_cmd(seqc(8'h00, 4'd15), ACK_OK, 1'b0, FILL_RAND, 1'b0);

		// OK reads and writes at the field extremes
		run_cmd(xfer(1'b1, 1'b1, 2'd3, 32'h0), ACK_OK, 1'b0, FILL_ONES, 1'b0);
		run_cmd(xfer(1'b0, 1'b1, 2'd0, 32'hffff_ffff), ACK_OK, 1'b0, FILL_ZERO, 1'b1);
		run_cmd(xfer(1'b1, 1'b0, 2'd3, 32'hffff_ffff), ACK_OK, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b0, 1'b0, 2'd0, 32'h0), ACK_OK, 1'b0, FILL_RAND, 1'b0);

		// Read parity error, WAIT, FAULT and malformed ACKs
		run_cmd(xfer(1'b0, 1'b1, 2'd1, $urandom), ACK_OK, 1'b1, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b1, 1'b1, 2'd2, $urandom), ACK_WAIT, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b0, 1'b0, 2'd1, $urandom), ACK_WAIT, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b1, 1'b1, 2'd0, $urandom), ACK_FAULT, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b0, 1'b0, 2'd2, $urandom), ACK_FAULT, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b1, 1'b1, 2'd1, $urandom), ACK_LINE_LOW, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b0, 1'b0, 2'd3, $urandom), ACK_LINE_HIGH, 1'b0, FILL_RAND, 1'b0);

		// Idle bits after successful transfers
		write_idle(8'd2);
		run_cmd(xfer(1'b1, 1'b0, 2'd2, $urandom), ACK_OK, 1'b0, FILL_RAND, 1'b0);
		run_cmd(xfer(1'b0, 1'b1, 2'd3, $urandom), ACK_OK, 1'b0, FILL_RAND, 1'b0);

		// Random traffic across idle settings, the extremes among them
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: v = '0;
				1: v = 8'd1;
				2: v = 8'hff;
				3: v = IDLE_W'($urandom_range(15));
				default: v = IDLE_W'($urandom_range(255));
			endcase
			write_idle(v);
			tx_gap_pct = (p == 1) ? 0 : $urandom_range(2) * 20;
			if (p == 2)
				hold_req = 1'b1;
			random_phase((p == 2) ? 25 : 12);
		end

		item_valid <= 1'b0;
		while (sb.bits_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("tb_swd_host_transfer_engine_core: PASS");
		else
			$display("tb_swd_host_transfer_engine_core: FAIL");
		$finish;
	end

endmodule
